// ----- hw/rtl/ftws_pkg.sv -----
// Shared types and constants for the frame time window statistics block.
package ftws_pkg;

  localparam int unsigned MILLIS_W     = 16;
  localparam int unsigned RATE_W       = 10;
  localparam int unsigned SAMPLE_W     = 10;
  localparam int unsigned MS_PER_SEC   = 1000;
  localparam int unsigned MAX_FRAME_MS = 1000;
  localparam int unsigned MIN_FRAME_MS = 1;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_UPDATE = 6'b000010,
    S_SCAN   = 6'b000100,
    S_LOAD   = 6'b001000,
    S_DIV    = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  typedef enum logic [1:0] {
    OP_AVG   = 2'd0,
    OP_BEST  = 2'd1,
    OP_WORST = 2'd2
  } div_op_t;

endpackage

// ----- hw/rtl/frame_time_window_stats.sv -----
// Moving window frame rate statistics: average, best gain and worst loss.
// Each frame takes an update, a memory scan of one entry per cycle and three divisions through
// one shared radix-2 divider of width SUM_W = clog2(WINDOW_LEN * 1000 + 1). A new frame is
// accepted only in idle; a result still waiting when the next one finishes holds the block.
// Reset clears the per-entry valid bits so that every sample reads as one, the write slot and
// the window sum to WINDOW_LEN; reset is synchronous.
module frame_time_window_stats #(
  parameter int unsigned WINDOW_LEN = 60
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          frame_valid,
  output logic                          frame_stall,
  input  logic [ftws_pkg::MILLIS_W-1:0] frame_millis,
  output logic                          stats_valid,
  input  logic                          stats_stall,
  output logic [ftws_pkg::RATE_W-1:0]   avg_rate,
  output logic [ftws_pkg::RATE_W-1:0]   best_gain,
  output logic [ftws_pkg::RATE_W-1:0]   worst_loss
);
  import ftws_pkg::*;

  localparam int unsigned SUM_W  = $clog2(WINDOW_LEN * MS_PER_SEC + 1);
  localparam int unsigned SLOT_W = $clog2(WINDOW_LEN);
  localparam int unsigned IDX_W  = $clog2(WINDOW_LEN + 1);
  localparam int unsigned CNT_W  = $clog2(SUM_W);

  state_t                state;
  div_op_t               op;
  logic [SAMPLE_W-1:0]   ring [WINDOW_LEN];
  logic [WINDOW_LEN-1:0] filled;
  logic [SAMPLE_W-1:0]   rd_data;
  logic                  rd_filled;
  logic [SLOT_W-1:0]     rd_addr;
  logic [SAMPLE_W-1:0]   sample;
  logic [SLOT_W-1:0]     slot;
  logic [IDX_W-1:0]      scan_idx;
  logic                  scan_pend;
  logic [SAMPLE_W-1:0]   ms;
  logic [SAMPLE_W-1:0]   ms_clamp;
  logic [SUM_W-1:0]      window_sum;
  logic [SAMPLE_W-1:0]   shortest;
  logic [SAMPLE_W-1:0]   longest;
  logic [SAMPLE_W-1:0]   shortest_next;
  logic [SAMPLE_W-1:0]   longest_next;
  logic [SUM_W-1:0]      dvd;
  logic [SUM_W-1:0]      dvs;
  logic [SUM_W-1:0]      rem;
  logic [SUM_W-1:0]      quo;
  logic [CNT_W-1:0]      div_cnt;
  logic [SUM_W:0]        rem_sh;
  logic                  rem_ge;
  logic [SUM_W-1:0]      rem_next;
  logic [SUM_W-1:0]      quo_next;
  logic [RATE_W-1:0]     avg_q;
  logic [RATE_W-1:0]     best_q;
  logic [RATE_W-1:0]     worst_q;
  logic                  frame_take;
  logic                  out_free;

  assign frame_stall = (state != S_IDLE);
  assign frame_take  = frame_valid && !frame_stall;
  assign out_free    = !stats_valid || !stats_stall;

  always_comb begin
    if (frame_millis < MILLIS_W'(MIN_FRAME_MS)) begin
      ms_clamp = SAMPLE_W'(MIN_FRAME_MS);
    end else if (frame_millis > MILLIS_W'(MAX_FRAME_MS)) begin
      ms_clamp = SAMPLE_W'(MAX_FRAME_MS);
    end else begin
      ms_clamp = frame_millis[SAMPLE_W-1:0];
    end
  end

  assign rd_addr = (state == S_SCAN) ? scan_idx[SLOT_W-1:0] : slot;
  assign sample  = rd_filled ? rd_data : SAMPLE_W'(MIN_FRAME_MS);

  always_ff @(posedge clk) begin
    if (state == S_UPDATE) begin
      ring[slot] <= ms;
    end
    rd_data <= ring[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filled    <= '0;
      rd_filled <= 1'b0;
    end else begin
      if (state == S_UPDATE) begin
        filled[slot] <= 1'b1;
      end
      rd_filled <= filled[rd_addr];
    end
  end

  always_comb begin
    shortest_next = shortest;
    longest_next  = longest;
    if (scan_pend) begin
      if (sample < shortest) begin
        shortest_next = sample;
      end
      if (sample > longest) begin
        longest_next = sample;
      end
    end
  end

  always_comb begin
    rem_sh   = {rem, dvd[SUM_W-1]};
    rem_ge   = (rem_sh >= {1'b0, dvs});
    rem_next = rem_ge ? SUM_W'(rem_sh - {1'b0, dvs}) : rem_sh[SUM_W-1:0];
    quo_next = {quo[SUM_W-2:0], rem_ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      op          <= OP_AVG;
      slot        <= '0;
      window_sum  <= SUM_W'(WINDOW_LEN * MIN_FRAME_MS);
      scan_idx    <= '0;
      scan_pend   <= 1'b0;
      div_cnt     <= '0;
      stats_valid <= 1'b0;
    end else begin
      if (stats_valid && !stats_stall && (state != S_DONE)) begin
        stats_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (frame_take) begin
            ms    <= ms_clamp;
            state <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          window_sum <= window_sum - SUM_W'(sample) + SUM_W'(ms);
          slot       <= (slot == SLOT_W'(WINDOW_LEN - 1)) ? '0 : slot + 1'b1;
          scan_idx   <= '0;
          scan_pend  <= 1'b0;
          shortest   <= SAMPLE_W'(MAX_FRAME_MS);
          longest    <= SAMPLE_W'(MIN_FRAME_MS);
          state      <= S_SCAN;
        end
        S_SCAN: begin
          shortest <= shortest_next;
          longest  <= longest_next;
          if (scan_idx != IDX_W'(WINDOW_LEN)) begin
            scan_idx  <= scan_idx + 1'b1;
            scan_pend <= 1'b1;
          end else begin
            scan_pend <= 1'b0;
            op        <= OP_AVG;
            state     <= S_LOAD;
          end
        end
        S_LOAD: begin
          rem     <= '0;
          quo     <= '0;
          div_cnt <= '0;
          unique case (op)
            OP_AVG: begin
              dvd <= SUM_W'(WINDOW_LEN * MS_PER_SEC);
              dvs <= window_sum;
            end
            OP_BEST: begin
              dvd <= SUM_W'(MS_PER_SEC);
              dvs <= SUM_W'(shortest);
            end
            default: begin
              dvd <= SUM_W'(MS_PER_SEC);
              dvs <= SUM_W'(longest);
            end
          endcase
          state <= S_DIV;
        end
        S_DIV: begin
          rem     <= rem_next;
          quo     <= quo_next;
          dvd     <= {dvd[SUM_W-2:0], 1'b0};
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == CNT_W'(SUM_W - 1)) begin
            unique case (op)
              OP_AVG: begin
                avg_q <= quo_next[RATE_W-1:0];
                op    <= OP_BEST;
                state <= S_LOAD;
              end
              OP_BEST: begin
                best_q <= quo_next[RATE_W-1:0];
                op     <= OP_WORST;
                state  <= S_LOAD;
              end
              default: begin
                worst_q <= quo_next[RATE_W-1:0];
                state   <= S_DONE;
              end
            endcase
          end
        end
        S_DONE: begin
          if (out_free) begin
            avg_rate    <= avg_q;
            best_gain   <= (best_q >= avg_q) ? best_q - avg_q : '0;
            worst_loss  <= (avg_q >= worst_q) ? avg_q - worst_q : '0;
            stats_valid <= 1'b1;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_sum_range: assert property (@(posedge clk) disable iff (rst)
    (window_sum >= SUM_W'(WINDOW_LEN)) &&
    (window_sum <= SUM_W'(WINDOW_LEN * MAX_FRAME_MS)))
    else $error("Window sum left its possible range.");

  a_divisor_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (dvs != '0))
    else $error("Divider started with a zero divisor.");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(stats_valid) |-> ($past(state) == S_DONE))
    else $error("Result presented without a finished computation.");

  a_avg_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) |-> ((avg_q != '0) && (avg_q <= RATE_W'(MS_PER_SEC))))
    else $error("Average rate out of range.");

endmodule

// ----- sim/tb_frame_time_window_stats.sv -----
// Self-checking testbench for the frame time window statistics block.
`timescale 1ns / 1ps

module tb_frame_time_window_stats;
  import ftws_pkg::*;

  localparam int unsigned WINDOW_LEN = 60;
  localparam int unsigned DRAIN_CYCLES = 130;

  typedef struct packed {
    logic [RATE_W-1:0] avg;
    logic [RATE_W-1:0] best;
    logic [RATE_W-1:0] worst;
  } frame_stats_t;

  typedef enum int unsigned {
    BURST_MIXED,
    BURST_FAST,
    BURST_SLOW,
    BURST_STEADY,
    BURST_RAW
  } burst_kind_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                frame_valid = 1'b0;
  logic                frame_stall;
  logic [MILLIS_W-1:0] frame_millis = '0;
  logic                stats_valid;
  logic                stats_stall = 1'b0;
  logic [RATE_W-1:0]   avg_rate;
  logic [RATE_W-1:0]   best_gain;
  logic [RATE_W-1:0]   worst_loss;

  logic [SAMPLE_W-1:0] frame_ring [WINDOW_LEN];
  int unsigned         ring_slot;
  int unsigned         ring_total;
  frame_stats_t        pending_stats [$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatches = 0;

  frame_time_window_stats #(
    .WINDOW_LEN(WINDOW_LEN)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .frame_valid (frame_valid),
    .frame_stall (frame_stall),
    .frame_millis(frame_millis),
    .stats_valid (stats_valid),
    .stats_stall (stats_stall),
    .avg_rate    (avg_rate),
    .best_gain   (best_gain),
    .worst_loss  (worst_loss)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  task automatic clear_window();
    for (int i = 0; i < WINDOW_LEN; i++) frame_ring[i] = SAMPLE_W'(MIN_FRAME_MS);
    ring_slot = 0;
    ring_total = WINDOW_LEN * MIN_FRAME_MS;
  endtask

  task automatic predict_window_stats(input logic [MILLIS_W-1:0] ms, output frame_stats_t res);
    int unsigned stored;
    int unsigned shortest;
    int unsigned longest;
    int unsigned avg;
    int unsigned best_rate;
    int unsigned worst_rate;
    stored = ms;
    if (stored < MIN_FRAME_MS) stored = MIN_FRAME_MS;
    if (stored > MAX_FRAME_MS) stored = MAX_FRAME_MS;
    ring_total = ring_total - frame_ring[ring_slot] + stored;
    frame_ring[ring_slot] = SAMPLE_W'(stored);
    ring_slot = (ring_slot == WINDOW_LEN - 1) ? 0 : ring_slot + 1;
    shortest = frame_ring[0];
    longest = frame_ring[0];
    for (int i = 1; i < WINDOW_LEN; i++) begin
      if (frame_ring[i] < shortest) shortest = frame_ring[i];
      if (frame_ring[i] > longest) longest = frame_ring[i];
    end
    if (shortest == 0) shortest = 1;
    if (longest == 0) longest = 1;
    avg = (ring_total != 0) ? (WINDOW_LEN * MS_PER_SEC) / ring_total : MS_PER_SEC;
    best_rate = MS_PER_SEC / shortest;
    worst_rate = MS_PER_SEC / longest;
    res.avg = RATE_W'(avg);
    res.best = RATE_W'((best_rate >= avg) ? best_rate - avg : 0);
    res.worst = RATE_W'((avg >= worst_rate) ? avg - worst_rate : 0);
  endtask

  task automatic send_frame(input logic [MILLIS_W-1:0] ms);
    frame_stats_t res;
    if ($urandom_range(99) < send_idle_pct) begin
      frame_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    frame_valid <= 1'b1;
    frame_millis <= ms;
    do @(posedge clk); while (frame_stall);
    predict_window_stats(ms, res);
    pending_stats.push_back(res);
  endtask

  task automatic wait_for_results();
    frame_valid <= 1'b0;
    do @(posedge clk); while (pending_stats.size() != 0);
  endtask

  always @(posedge clk) begin
    frame_stats_t want;
    if (rst) begin
      stats_stall <= 1'b0;
    end else begin
      if (stats_valid && !stats_stall) begin
        if (pending_stats.size() == 0) begin
          report_mismatch($sformatf("result with none expected (avg %0d best %0d worst %0d)",
                                    avg_rate, best_gain, worst_loss));
        end else begin
          want = pending_stats.pop_front();
          if (avg_rate !== want.avg)
            report_mismatch($sformatf("avg_rate %0d, expected %0d", avg_rate, want.avg));
          if (best_gain !== want.best)
            report_mismatch($sformatf("best_gain %0d, expected %0d", best_gain, want.best));
          if (worst_loss !== want.worst)
            report_mismatch($sformatf("worst_loss %0d, expected %0d", worst_loss, want.worst));
        end
      end
      stats_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  function automatic logic [MILLIS_W-1:0] pick_frame_time(input burst_kind_t kind,
                                                         input int unsigned center);
    int unsigned roll;
    int unsigned lo;
    int unsigned hi;
    roll = $urandom_range(99);
    case (kind)
      BURST_FAST: begin
        return (roll < 5) ? '0 : MILLIS_W'($urandom_range(30, 1));
      end
      BURST_SLOW: begin
        if (roll < 8) return MILLIS_W'($urandom_range(65535, 1001));
        return MILLIS_W'($urandom_range(1000, 400));
      end
      BURST_STEADY: begin
        lo = (center > 5) ? center - 5 : 0;
        hi = (center + 5 > 1005) ? 1005 : center + 5;
        return MILLIS_W'($urandom_range(hi, lo));
      end
      BURST_RAW: begin
        return MILLIS_W'($urandom_range(65535, 0));
      end
      default: begin
        if (roll < 5) return '0;
        if (roll < 10) return MILLIS_W'($urandom_range(65535, 1001));
        return MILLIS_W'($urandom_range(1000, 1));
      end
    endcase
  endfunction

  task automatic test_reset_window();
    send_frame(16'd1);
    send_frame(16'd1000);
    send_frame(16'd1);
  endtask

  task automatic test_clamping();
    send_frame(16'd0);
    send_frame(16'd1001);
    send_frame(16'hFFFF);
    send_frame(16'h8000);
    send_frame(16'h5555);
    send_frame(16'hAAAA);
    send_frame(16'h7FFF);
    send_frame(16'h00FF);
    send_frame(16'd999);
    send_frame(16'd2);
    send_frame(16'd0);
  endtask

  task automatic test_drain_pause();
    for (int i = 0; i < 5; i++) begin
      wait_for_results();
      send_frame(MILLIS_W'($urandom_range(1000, 0)));
    end
    wait_for_results();
  endtask

  task automatic test_random_traffic(input int unsigned count);
    burst_kind_t kind;
    int unsigned left;
    int unsigned center;
    left = 0;
    kind = BURST_MIXED;
    center = 500;
    for (int unsigned n = 0; n < count; n++) begin
      if (left == 0) begin
        case ($urandom_range(9)) inside
          [0:2]:   kind = BURST_MIXED;
          [3:4]:   kind = BURST_FAST;
          [5:6]:   kind = BURST_SLOW;
          [7:8]:   kind = BURST_STEADY;
          default: kind = BURST_RAW;
        endcase
        center = $urandom_range(1000, 0);
        left = $urandom_range(120, 20);
      end
      left--;
      send_frame(pick_frame_time(kind, center));
    end
  endtask

  initial begin
    clear_window();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 16;
    recv_stall_pct = 46;
    test_reset_window();
    test_clamping();
    test_drain_pause();
    test_random_traffic(510);

    send_idle_pct = 46;
    recv_stall_pct = 16;
    test_random_traffic(510);

    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_random_traffic(510);

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #12000000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/ftws_pkg.sv
hw/rtl/frame_time_window_stats.sv
sim/tb_frame_time_window_stats.sv
